// ===== rtl/core/e2q_pkg.sv =====
// Shared types, constants and helpers for the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_BITS   = 16;
  localparam int NUM_ITERS  = 32;
  localparam int INT_FRAC   = 30;
  localparam int CW         = 36;   // CORDIC datapath width
  localparam int SW         = 40;   // width of the saturation helper input
  localparam int CORDIC_LAT = NUM_ITERS + 1;
  localparam int COMB_LAT   = 3;
  localparam int TOTAL_LAT  = CORDIC_LAT + COMB_LAT;

  localparam logic [31:0] CORDIC_START = 32'd652032874;

  localparam logic [31:0] ATAN_TABLE [NUM_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
    logic signed [OUT_BITS-1:0] quat_w;
  } out_item_t;

  // Clamp to +-2^FRAC_BITS.
  function automatic logic signed [OUT_BITS-1:0] sat_unit(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] one;
    logic signed [OUT_BITS-1:0] res;
    one = SW'(1) <<< FRAC_BITS;
    if (v > one) res = OUT_BITS'(one);
    else if (v < -one) res = OUT_BITS'(-one);
    else res = OUT_BITS'(v);
    return res;
  endfunction

endpackage

// ===== rtl/core/euler_angles_to_quaternion_unit.sv =====
// Top level of the Euler angle to unit quaternion converter.
//
// Input channel in_*: one item is a roll, pitch, yaw triple of 16-bit binary
// angles (32768 stands for pi). Output channel out_*: one item is the unit
// quaternion x, y, z, w in signed Q1.14, each clamped to +-16384.
// Every input item yields exactly one output item, in order.
//
// From acceptance to out_valid an item passes 32 CORDIC iteration
// stages, one rounding stage, then pair products, yaw products and the
// final sum and clamp. One item per cycle while the receiver does not
// stall; the three angles run through three CORDIC pipelines side by side.
//
// Reset clears all valid bits; results in flight are dropped.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and in_stall rises, so nothing is lost or repeated. Empty slots are
// not squeezed out during a hold.
module euler_angles_to_quaternion_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  e2q_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output e2q_pkg::out_item_t  out_data
);

  localparam int L = e2q_pkg::TOTAL_LAT;

  logic         en;
  logic [L-1:0] vld;
  logic signed [e2q_pkg::OUT_BITS-1:0] cr, sr, cp, sp, cy, sy;

  assign out_valid = vld[L-1];
  assign en        = !(vld[L-1] && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  e2q_cordic u_roll (
    .clk(clk), .en(en), .angle(in_data.roll_angle), .cos_val(cr), .sin_val(sr)
  );

  e2q_cordic u_pitch (
    .clk(clk), .en(en), .angle(in_data.pitch_angle), .cos_val(cp), .sin_val(sp)
  );

  e2q_cordic u_yaw (
    .clk(clk), .en(en), .angle(in_data.yaw_angle), .cos_val(cy), .sin_val(sy)
  );

  e2q_combine u_combine (
    .clk(clk), .en(en),
    .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .quat(out_data)
  );

endmodule

// ===== rtl/core/e2q_cordic.sv =====
// Pipelined rotation CORDIC: cosine and sine of half of a binary angle.
module e2q_cordic (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0]  angle,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    cos_val,
  output logic signed [e2q_pkg::OUT_BITS-1:0]    sin_val
);

  localparam int W  = e2q_pkg::CW;
  localparam int N  = e2q_pkg::NUM_ITERS;
  localparam int RS = e2q_pkg::INT_FRAC - e2q_pkg::FRAC_BITS;

  logic signed [W-1:0] xs [0:N];
  logic signed [W-1:0] ys [0:N];
  logic signed [W-1:0] zs [0:N];
  logic signed [W-1:0] x_rnd;
  logic signed [W-1:0] y_rnd;

  assign xs[0] = W'(e2q_pkg::CORDIC_START);
  assign ys[0] = '0;
  // Half-angle in units of pi/2^32.
  assign zs[0] = {{(W-32){angle[e2q_pkg::ANGLE_BITS-1]}}, angle,
                  {(32-e2q_pkg::ANGLE_BITS){1'b0}}};

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [W-1:0] da;
    assign da = W'({e2q_pkg::ATAN_TABLE[i], 1'b0});
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i][W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + da;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - da;
        end
      end
    end
  end

  assign x_rnd = (xs[N] + (W'(1) <<< (RS - 1))) >>> RS;
  assign y_rnd = (ys[N] + (W'(1) <<< (RS - 1))) >>> RS;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= e2q_pkg::sat_unit(e2q_pkg::SW'(x_rnd));
      sin_val <= e2q_pkg::sat_unit(e2q_pkg::SW'(y_rnd));
    end
  end

endmodule

// ===== rtl/core/e2q_combine.sv =====
// Three-stage product and sum network forming the quaternion components.
module e2q_combine (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  cr,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  sr,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  cp,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  sp,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  cy,
  input  logic signed [e2q_pkg::OUT_BITS-1:0]  sy,
  output e2q_pkg::out_item_t                   quat
);

  localparam int FB = e2q_pkg::FRAC_BITS;
  localparam int IW = e2q_pkg::OUT_BITS;
  localparam int PW = 2 * IW;      // raw product
  localparam int RW = IW + 2;      // rounded pair product
  localparam int TW = RW + IW;     // triple product
  localparam int AW = TW + 1;      // sum

  // Stage A: rounded pair products.
  logic signed [PW-1:0] m_sc, m_cs, m_cc, m_ss;
  logic signed [RW-1:0] p_sc, p_cs, p_cc, p_ss;
  logic signed [IW-1:0] cy_a, sy_a;

  assign m_sc = PW'(sr) * PW'(cp);
  assign m_cs = PW'(cr) * PW'(sp);
  assign m_cc = PW'(cr) * PW'(cp);
  assign m_ss = PW'(sr) * PW'(sp);

  always_ff @(posedge clk) begin
    if (en) begin
      p_sc <= RW'((m_sc + (PW'(1) <<< (FB - 1))) >>> FB);
      p_cs <= RW'((m_cs + (PW'(1) <<< (FB - 1))) >>> FB);
      p_cc <= RW'((m_cc + (PW'(1) <<< (FB - 1))) >>> FB);
      p_ss <= RW'((m_ss + (PW'(1) <<< (FB - 1))) >>> FB);
      cy_a <= cy;
      sy_a <= sy;
    end
  end

  // Stage B: multiply by the yaw factor.
  logic signed [TW-1:0] xa, xb, ya, yb, za, zb, wa, wb;

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= TW'(p_sc) * TW'(cy_a);
      xb <= TW'(p_cs) * TW'(sy_a);
      ya <= TW'(p_cs) * TW'(cy_a);
      yb <= TW'(p_sc) * TW'(sy_a);
      za <= TW'(p_cc) * TW'(sy_a);
      zb <= TW'(p_ss) * TW'(cy_a);
      wa <= TW'(p_cc) * TW'(cy_a);
      wb <= TW'(p_ss) * TW'(sy_a);
    end
  end

  // Stage C: sum, round, clamp.
  logic signed [AW-1:0] sx, sy_s, sz, sw;

  assign sx   = ((AW'(xa) - AW'(xb)) + (AW'(1) <<< (FB - 1))) >>> FB;
  assign sy_s = ((AW'(ya) + AW'(yb)) + (AW'(1) <<< (FB - 1))) >>> FB;
  assign sz   = ((AW'(za) - AW'(zb)) + (AW'(1) <<< (FB - 1))) >>> FB;
  assign sw   = ((AW'(wa) + AW'(wb)) + (AW'(1) <<< (FB - 1))) >>> FB;

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_x <= e2q_pkg::sat_unit(e2q_pkg::SW'(sx));
      quat.quat_y <= e2q_pkg::sat_unit(e2q_pkg::SW'(sy_s));
      quat.quat_z <= e2q_pkg::sat_unit(e2q_pkg::SW'(sz));
      quat.quat_w <= e2q_pkg::sat_unit(e2q_pkg::SW'(sw));
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the Euler angle to quaternion converter.
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1750;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  e2q_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  e2q_pkg::out_item_t out_data;

  euler_angles_to_quaternion_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  e2q_pkg::in_item_t angle_queue[$];
  e2q_pkg::out_item_t quat_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_send = 0;
  bit in_taken = 0;
  int quiet_cycles = 0;

  // 64-bit two's complement helpers mirroring the fixed-point arithmetic
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [63:0] clamp_unit(logic signed [63:0] v);
    logic signed [63:0] one;
    one = 64'sd1 <<< e2q_pkg::FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic void half_trig(input logic signed [15:0] ang,
                                    output logic signed [63:0] c,
                                    output logic signed [63:0] s);
    logic signed [63:0] x, y, z, dx, dy, da;
    z = 64'(ang) <<< 16;
    x = 64'(e2q_pkg::CORDIC_START);
    y = 0;
    for (int i = 0; i < e2q_pkg::NUM_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = 64'(e2q_pkg::ATAN_TABLE[i]) << 1;
      if (z < 0) begin
        x = x + dx; y = y - dy; z = z + da;
      end else begin
        x = x - dx; y = y + dy; z = z - da;
      end
    end
    c = clamp_unit(rnd_shift(x, e2q_pkg::INT_FRAC - e2q_pkg::FRAC_BITS));
    s = clamp_unit(rnd_shift(y, e2q_pkg::INT_FRAC - e2q_pkg::FRAC_BITS));
  endfunction

  function automatic logic signed [15:0] mix(logic signed [63:0] a, b, c, d, e, f, bit sub);
    logic signed [63:0] p, q, sum;
    p = rnd_shift(a * b, e2q_pkg::FRAC_BITS) * c;
    q = rnd_shift(d * e, e2q_pkg::FRAC_BITS) * f;
    sum = sub ? p - q : p + q;
    return 16'(clamp_unit(rnd_shift(sum, e2q_pkg::FRAC_BITS)));
  endfunction

  function automatic e2q_pkg::out_item_t predict_quat(e2q_pkg::in_item_t a);
    logic signed [63:0] cr, sr, cp, sp, cy, sy;
    e2q_pkg::out_item_t q;
    half_trig(a.roll_angle, cr, sr);
    half_trig(a.pitch_angle, cp, sp);
    half_trig(a.yaw_angle, cy, sy);
    q.quat_x = mix(sr, cp, cy, cr, sp, sy, 1);
    q.quat_y = mix(cr, sp, cy, sr, cp, sy, 0);
    q.quat_z = mix(cr, cp, sy, sr, sp, cy, 1);
    q.quat_w = mix(cr, cp, cy, sr, sp, sy, 0);
    return q;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: change inputs on the falling edge, hold until the item is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      out_stall <= 0;
      in_data <= '0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!in_valid || in_taken) begin
        if (!hold_send && angle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= angle_queue.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: score both channels on the rising edge.
  always @(posedge clk) begin
    bit busy;
    busy = 0;
    in_taken = 0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        quat_queue.push_back(predict_quat(in_data));
        n_sent <= n_sent + 1;
        in_taken = 1;
        busy = 1;
      end
      if (out_valid && !out_stall) begin
        busy = 1;
        n_checked <= n_checked + 1;
        if (quat_queue.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected item %h", $time, out_data);
        end else if (quat_queue[0] !== out_data) begin
          errors <= errors + 1;
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d actual x=%0d y=%0d z=%0d w=%0d",
                   $time, quat_queue[0].quat_x, quat_queue[0].quat_y, quat_queue[0].quat_z,
                   quat_queue[0].quat_w, out_data.quat_x, out_data.quat_y, out_data.quat_z,
                   out_data.quat_w);
          void'(quat_queue.pop_front());
        end else begin
          void'(quat_queue.pop_front());
        end
      end
      quiet_cycles <= busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_item(logic [15:0] r, p, y);
    e2q_pkg::in_item_t a;
    a.roll_angle = r; a.pitch_angle = p; a.yaw_angle = y;
    angle_queue.push_back(a);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'h8000 + 16'($urandom_range(3));
      1: return 16'h7FFF - 16'($urandom_range(3));
      2: return 16'($signed($urandom_range(64)) - 32);
      3: return {$urandom_range(3) == 0 ? 2'b11 : 2'b00, 14'($urandom)} ^ 16'h4000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (angle_queue.size() > 0 || in_valid || quat_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] corners[8];
    rst = 1;
    corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF, 16'h2000};
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 0;

    // Directed: axis extremes, quarter turns and the most negative angle.
    for (int i = 0; i < 8; i++) add_item(corners[i], 16'h0000, 16'h0000);
    for (int i = 1; i < 8; i++) add_item(16'h0000, corners[i], 16'h0000);
    for (int i = 1; i < 8; i++) add_item(16'h0000, 16'h0000, corners[i]);
    add_item(16'h8000, 16'h8000, 16'h8000);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_item(16'h4000, 16'h4000, 16'hC000);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 88 : 0;
      recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 25 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        add_item(rand_angle(), rand_angle(), rand_angle());
        if (i == N_RANDOM / 6) begin
          // pause the sender until every pending quaternion is out
          while (angle_queue.size() > 0 || in_valid) @(posedge clk);
          hold_send = 1;
          while (quat_queue.size() > 0) @(posedge clk);
          hold_send = 0;
        end
      end
      wait_drained();
    end

    repeat (e2q_pkg::TOTAL_LAT + 10) @(posedge clk);
    $display("Checked %0d quaternions from %0d angle triples: axis extremes, then random",
             n_checked, n_sent);
    $display("angles under three stall mixes on both channels.");
    if (errors == 0 && quat_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/e2q_pkg.sv
rtl/core/e2q_cordic.sv
rtl/core/e2q_combine.sv
rtl/core/euler_angles_to_quaternion_unit.sv
verif/testbench.sv
